FILE: hw/rtl/frt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package frt_pkg;

    // widest slot index the table supports
    localparam int unsigned SLOT_IDX_BITS = 6;

    // register indexes on the configuration port
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    // result codes
    localparam logic [1:0] ST_DROP     = 2'd0;
    localparam logic [1:0] ST_ACCEPT   = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_COMPLETE = 2'd3;

    // slot bookkeeping request, one operation per cycle
    typedef struct packed {
        logic                     free_en;
        logic [SLOT_IDX_BITS-1:0] free_idx;
        logic                     open_en;
        logic [SLOT_IDX_BITS-1:0] open_idx;
    } t_age_op;

endpackage
`default_nettype wire

FILE: hw/rtl/frt_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module frt_mem #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3,
    parameter int unsigned DW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/frt_age.sv
`timescale 1ns / 1ps
`default_nettype none
module frt_age
    import frt_pkg::*;
#(
    parameter int unsigned SLOTS = 8,
    parameter int unsigned SW    = 3,
    parameter int unsigned CW    = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_age_op        i_op,
    output logic [SLOTS-1:0]    o_valid,
    output logic [CW-1:0]       o_count,
    output logic [SW-1:0]       o_oldest,
    output logic [SW-1:0]       o_first_free,
    output logic                o_free_any
);

    logic [SLOTS-1:0] r_valid;
    logic [CW-1:0]    r_count;
    logic [SW-1:0]    r_rank [SLOTS];
    logic [SW-1:0]    free_idx;
    logic [SW-1:0]    open_idx;

    assign free_idx = i_op.free_idx[SW-1:0];
    assign open_idx = i_op.open_idx[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_op.free_en && r_valid[free_idx]) begin
            r_valid[free_idx] <= 1'b0;
            r_count <= r_count - CW'(1);
        end else if (i_op.open_en) begin
            r_valid[open_idx] <= 1'b1;
            r_count <= r_count + CW'(1);
        end
    end

    // ranks close the gap left by a freed slot
    always_ff @(posedge i_clk) begin
        if (i_op.free_en && r_valid[free_idx]) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (r_valid[i] && (r_rank[i] > r_rank[free_idx])) begin
                    r_rank[i] <= r_rank[i] - SW'(1);
                end
            end
        end else if (i_op.open_en) begin
            r_rank[open_idx] <= SW'(r_count);
        end
    end

    always_comb begin
        o_oldest     = '0;
        o_first_free = '0;
        o_free_any   = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_rank[i] == '0)) begin
                o_oldest = SW'(i);
            end
            if (!r_valid[i]) begin
                o_first_free = SW'(i);
                o_free_any   = 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_count = r_count;

endmodule
`default_nettype wire

FILE: hw/rtl/fragment_reassembly_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// an invalid header gives its result in the cycle after start; a valid one goes through
//   the read-then-check walk over the slot memory, then the evict, alloc and update states
// throughput: one item at a time, next start accepted once busy falls
// the receiver cannot stall: each result is shown for one cycle under o_valid
// reset (synchronous, active low) clears all slot valid bits and loads register defaults
module fragment_reassembly_tracker
    import frt_pkg::*;
#(
    parameter int unsigned SLOTS       = 8,
    parameter int unsigned MAX_FRAGS   = 16,
    parameter int unsigned MAX_PAYLOAD = 64,
    parameter int unsigned MAX_MESSAGE = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command handshake
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_group_id,
    input  wire logic [15:0] i_source_id,
    input  wire logic [15:0] i_message_id,
    input  wire logic [7:0]  i_msg_type,
    input  wire logic [7:0]  i_frag_index,
    input  wire logic [7:0]  i_frag_total,
    input  wire logic [7:0]  i_declared_length,
    input  wire logic [7:0]  i_actual_length,
    input  wire logic [31:0] i_now_time,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    // result beat
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [2:0]       o_slot_used,
    output logic [10:0]      o_message_bytes
);

    localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW  = $clog2(SLOTS + 1);
    localparam int unsigned FW  = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
    localparam int unsigned NW  = $clog2(MAX_FRAGS + 1);
    localparam int unsigned BW  = $clog2(MAX_MESSAGE + 1);
    localparam int unsigned LW  = (CW > 4) ? CW : 4;

    // one memory word per slot
    typedef struct packed {
        logic [7:0]           grp;
        logic [15:0]          src;
        logic [15:0]          msg;
        logic [7:0]           typ;
        logic [7:0]           tot;
        logic [31:0]          expiry;
        logic [MAX_FRAGS-1:0] seen;
        logic [NW-1:0]        cnt;
        logic [BW-1:0]        bytes;
    } t_entry;

    localparam int unsigned EW = $bits(t_entry);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_CHK   = 6'b000100,
        S_EVICT = 6'b001000,
        S_ALLOC = 6'b010000,
        S_UPD   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [31:0] r_timeout;
    logic [3:0]  r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 32'd30000;
            r_limit   <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_LIMIT:   r_limit   <= i_cfg_data[3:0];
                default:     r_timeout <= r_timeout;
            endcase
        end
    end

    // effective limit: 0 acts as 1, above SLOTS acts as SLOTS
    logic [LW-1:0] lim;
    always_comb begin
        lim = LW'(r_limit);
        if (lim == '0) begin
            lim = LW'(1);
        end
        if (lim > LW'(SLOTS)) begin
            lim = LW'(SLOTS);
        end
    end

    // latched command beat
    logic [7:0]  r_grp, r_typ, r_idx, r_tot, r_alen;
    logic [15:0] r_src, r_msg;
    logic [31:0] r_now;

    // header check on the live command
    logic hdr_ok;
    assign hdr_ok = (i_frag_total != 8'd0)
                 && ({1'b0, i_frag_total} <= 9'(MAX_FRAGS))
                 && (i_frag_index < i_frag_total)
                 && ({1'b0, i_declared_length} <= 9'(MAX_PAYLOAD))
                 && (i_actual_length == i_declared_length);

    // walk and lookup state
    logic [SW-1:0] r_ptr;
    logic          r_hit;
    logic [SW-1:0] r_slot;
    t_entry        r_ent;

    // slot bookkeeping
    t_age_op          age_op;
    logic [SLOTS-1:0] slot_valid;
    logic [CW-1:0]    slot_count;
    logic [SW-1:0]    oldest;
    logic [SW-1:0]    first_free;
    logic             free_any;

    frt_age #(.SLOTS(SLOTS), .SW(SW), .CW(CW)) u_age (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (age_op),
        .o_valid      (slot_valid),
        .o_count      (slot_count),
        .o_oldest     (oldest),
        .o_first_free (first_free),
        .o_free_any   (free_any)
    );

    // slot memory
    logic          mem_rd_en;
    logic [EW-1:0] mem_rd_data;
    logic          mem_wr_en;
    t_entry        mem_wr_data;
    t_entry        rd_ent;

    assign rd_ent = t_entry'(mem_rd_data);

    frt_mem #(.DEPTH(SLOTS), .AW(SW), .DW(EW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (mem_wr_data)
    );

    // slot being checked in the walk
    // expiry reached when the wrapped difference is not negative
    logic        expired, key_hit;
    logic [31:0] since;
    assign since   = r_now - rd_ent.expiry;
    assign expired = slot_valid[r_ptr] && !since[31];
    assign key_hit = slot_valid[r_ptr] && (rd_ent.grp == r_grp) && (rd_ent.src == r_src)
                  && (rd_ent.msg == r_msg) && (rd_ent.typ == r_typ) && (rd_ent.tot == r_tot);

    // update math on the selected entry
    logic            dup;
    logic [BW:0]     sum;
    logic            ovf;
    logic [NW-1:0]   cnt_inc;
    logic            done;
    logic [FW-1:0]   bit_idx;

    assign bit_idx = r_idx[FW-1:0];
    assign dup     = r_ent.seen[bit_idx];
    assign sum     = {1'b0, r_ent.bytes} + (BW + 1)'(r_alen);
    assign ovf     = sum > (BW + 1)'(MAX_MESSAGE);
    assign cnt_inc = r_ent.cnt + NW'(1);
    assign done    = 9'(cnt_inc) == {1'b0, r_tot};

    always_comb begin
        mem_wr_data = r_ent;
        mem_wr_data.seen[bit_idx] = 1'b1;
        mem_wr_data.cnt    = cnt_inc;
        mem_wr_data.bytes  = sum[BW-1:0];
        mem_wr_data.expiry = r_now + r_timeout;
    end

    assign mem_rd_en = (r_state == S_RD);
    assign mem_wr_en = (r_state == S_UPD) && !dup && !ovf;

    // sequencer
    always_comb begin
        n_state = r_state;
        age_op  = '0;
        case (r_state)
            S_IDLE: begin
                if (start && hdr_ok) begin
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (expired) begin
                    age_op.free_en  = 1'b1;
                    age_op.free_idx = SLOT_IDX_BITS'(r_ptr);
                end
                n_state = (r_ptr == SW'(SLOTS - 1)) ? S_EVICT : S_RD;
            end
            S_EVICT: begin
                if (!r_hit && (LW'(slot_count) >= lim)) begin
                    age_op.free_en  = 1'b1;
                    age_op.free_idx = SLOT_IDX_BITS'(oldest);
                end
                n_state = S_ALLOC;
            end
            S_ALLOC: begin
                if (!r_hit && free_any) begin
                    age_op.open_en  = 1'b1;
                    age_op.open_idx = SLOT_IDX_BITS'(first_free);
                end
                n_state = (r_hit || free_any) ? S_UPD : S_IDLE;
            end
            S_UPD: begin
                if (!dup && (ovf || done)) begin
                    age_op.free_en  = 1'b1;
                    age_op.free_idx = SLOT_IDX_BITS'(r_slot);
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hit   <= 1'b0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_hit <= 1'b0;
                    r_ptr <= '0;
                end
                S_CHK: begin
                    if (!expired && key_hit && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (r_ptr != SW'(SLOTS - 1)) begin
                        r_ptr <= r_ptr + SW'(1);
                    end
                end
                default: r_hit <= r_hit;
            endcase
        end
    end

    // payload side of the walk
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_grp  <= i_group_id;
            r_src  <= i_source_id;
            r_msg  <= i_message_id;
            r_typ  <= i_msg_type;
            r_idx  <= i_frag_index;
            r_tot  <= i_frag_total;
            r_alen <= i_actual_length;
            r_now  <= i_now_time;
        end
        if (r_state == S_CHK && !expired && key_hit && !r_hit) begin
            r_slot <= r_ptr;
            r_ent  <= rd_ent;
        end
        if (r_state == S_ALLOC && !r_hit) begin
            r_slot       <= first_free;
            r_ent.grp    <= r_grp;
            r_ent.src    <= r_src;
            r_ent.msg    <= r_msg;
            r_ent.typ    <= r_typ;
            r_ent.tot    <= r_tot;
            r_ent.expiry <= r_now + r_timeout;
            r_ent.seen   <= '0;
            r_ent.cnt    <= '0;
            r_ent.bytes  <= '0;
        end
    end

    // result beat
    logic r_out_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == S_IDLE && start && !hdr_ok)
                        || (r_state == S_ALLOC && !r_hit && !free_any)
                        || (r_state == S_UPD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            o_slot_used <= 3'(r_slot);
            if (dup) begin
                o_status        <= ST_DUP;
                o_message_bytes <= 11'(r_ent.bytes);
            end else if (ovf) begin
                o_status        <= ST_DROP;
                o_message_bytes <= '0;
            end else begin
                o_status        <= done ? ST_COMPLETE : ST_ACCEPT;
                o_message_bytes <= 11'(sum);
            end
        end else begin
            o_status        <= ST_DROP;
            o_slot_used     <= '0;
            o_message_bytes <= '0;
        end
    end

    assign o_valid = r_out_valid;
    assign busy    = (r_state != S_IDLE);

    // checks on the bookkeeping
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'($countones(slot_valid)) == slot_count)
        else $error("slot count out of step with valid bits");
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(age_op.free_en && age_op.open_en))
        else $error("free and open in one cycle");
    a_upd_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state == S_IDLE) && o_valid)
        else $error("update did not end in a result beat");
    a_wr_only_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |-> (r_state == S_UPD))
        else $error("slot memory written outside update");

endmodule
`default_nettype wire

FILE: tb/sv/fragment_reassembly_tracker_checker.sv
`timescale 1ns / 1ps
module fragment_reassembly_tracker_checker
    import frt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [7:0]  i_group_id,
    input  wire logic [15:0] i_source_id,
    input  wire logic [15:0] i_message_id,
    input  wire logic [7:0]  i_msg_type,
    input  wire logic [7:0]  i_frag_index,
    input  wire logic [7:0]  i_frag_total,
    input  wire logic [7:0]  i_declared_length,
    input  wire logic [7:0]  i_actual_length,
    input  wire logic [31:0] i_now_time,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        o_valid,
    input  wire logic [1:0]  o_status,
    input  wire logic [2:0]  o_slot_used,
    input  wire logic [10:0] o_message_bytes,
    output int               o_fail_count,
    output int               o_pending
);
    localparam int NSLOT = 8;
    localparam int FRAG_MAX = 16;
    localparam int PAYLOAD_MAX = 64;
    localparam int MESSAGE_MAX = 1024;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [10:0] bytes;
    } t_verdict;

    t_verdict verdict_q[$];

    logic [31:0] lifetime;
    logic [3:0]  limit_reg;
    logic        tbl_live   [NSLOT];
    logic [7:0]  tbl_group  [NSLOT];
    logic [15:0] tbl_source [NSLOT];
    logic [15:0] tbl_msg    [NSLOT];
    logic [7:0]  tbl_type   [NSLOT];
    logic [7:0]  tbl_total  [NSLOT];
    logic [31:0] tbl_expiry [NSLOT];
    logic [15:0] tbl_seen   [NSLOT];
    int          tbl_count  [NSLOT];
    int          tbl_bytes  [NSLOT];
    int          tbl_rank   [NSLOT];

    assign o_pending = verdict_q.size();

    function automatic void release_slot(int s);
        if (!tbl_live[s]) return;
        tbl_live[s] = 1'b0;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_live[i] && tbl_rank[i] > tbl_rank[s]) tbl_rank[i]--;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) if (tbl_live[i]) n++;
        return n;
    endfunction

    // track one fragment beat and return its outcome
    function automatic t_verdict track_fragment(
        logic [7:0] grp, logic [15:0] src, logic [15:0] msg, logic [7:0] typ,
        logic [7:0] idx, logic [7:0] tot, logic [7:0] dlen, logic [7:0] alen,
        logic [31:0] now);
        t_verdict r;
        int s, lim, oldest;
        logic [31:0] diff;
        r = '0;
        if (tot < 1 || tot > FRAG_MAX || idx >= tot || dlen > PAYLOAD_MAX || alen != dlen)
            return r;
        for (int i = 0; i < NSLOT; i++) begin
            diff = now - tbl_expiry[i];
            if (tbl_live[i] && !diff[31]) release_slot(i);
        end
        s = NSLOT;
        for (int i = 0; i < NSLOT; i++)
            if (s == NSLOT && tbl_live[i] && tbl_group[i] == grp && tbl_source[i] == src &&
                tbl_msg[i] == msg && tbl_type[i] == typ && tbl_total[i] == tot)
                s = i;
        if (s == NSLOT) begin
            lim = limit_reg;
            if (lim < 1) lim = 1;
            if (lim > NSLOT) lim = NSLOT;
            if (live_count() >= lim) begin
                oldest = NSLOT;
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_live[i] && (oldest == NSLOT || tbl_rank[i] < tbl_rank[oldest]))
                        oldest = i;
                if (oldest != NSLOT) release_slot(oldest);
            end
            for (int i = 0; i < NSLOT; i++)
                if (s == NSLOT && !tbl_live[i]) s = i;
            if (s == NSLOT) return r;
            tbl_rank[s]   = live_count();
            tbl_live[s]   = 1'b1;
            tbl_group[s]  = grp;
            tbl_source[s] = src;
            tbl_msg[s]    = msg;
            tbl_type[s]   = typ;
            tbl_total[s]  = tot;
            tbl_expiry[s] = now + lifetime;
            tbl_seen[s]   = '0;
            tbl_count[s]  = 0;
            tbl_bytes[s]  = 0;
        end
        r.slot = s[2:0];
        if (tbl_seen[s][idx[3:0]]) begin
            r.status = ST_DUP;
            r.bytes  = tbl_bytes[s][10:0];
            return r;
        end
        if (tbl_bytes[s] + alen > MESSAGE_MAX) begin
            release_slot(s);
            r.status = ST_DROP;
            return r;
        end
        tbl_seen[s][idx[3:0]] = 1'b1;
        tbl_count[s]++;
        tbl_bytes[s] += alen;
        tbl_expiry[s] = now + lifetime;
        r.bytes = tbl_bytes[s][10:0];
        if (tbl_count[s] != tbl_total[s]) begin
            r.status = ST_ACCEPT;
        end else begin
            r.status = ST_COMPLETE;
            release_slot(s);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (!i_rst_n) begin
            lifetime  = 32'd30000;
            limit_reg = 4'd8;
            for (int i = 0; i < NSLOT; i++) tbl_live[i] = 1'b0;
            verdict_q.delete();
            o_fail_count = 0;
        end else begin
            // result first: it belongs to an earlier beat
            if (o_valid) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result status=%0d slot=%0d bytes=%0d",
                             $time, o_status, o_slot_used, o_message_bytes);
                    o_fail_count++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (o_status !== exp_v.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_v.status, o_status);
                        o_fail_count++;
                    end
                    if (o_slot_used !== exp_v.slot) begin
                        $display("%0t: slot_used expected %0d actual %0d",
                                 $time, exp_v.slot, o_slot_used);
                        o_fail_count++;
                    end
                    if (o_message_bytes !== exp_v.bytes) begin
                        $display("%0t: message_bytes expected %0d actual %0d",
                                 $time, exp_v.bytes, o_message_bytes);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TIMEOUT) lifetime = i_cfg_data;
                else limit_reg = i_cfg_data[3:0];
            end
            if (start && !busy)
                verdict_q = {verdict_q, track_fragment(i_group_id, i_source_id,
                    i_message_id, i_msg_type, i_frag_index, i_frag_total,
                    i_declared_length, i_actual_length, i_now_time)};
        end
    end
endmodule

FILE: tb/sv/fragment_reassembly_tracker_tb.sv
`timescale 1ns / 1ps
module fragment_reassembly_tracker_tb;
    import frt_pkg::*;

    localparam int RANDOM_BEATS = 440;
    localparam int STALL_LIMIT  = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_group_id = '0;
    logic [15:0] i_source_id = '0;
    logic [15:0] i_message_id = '0;
    logic [7:0]  i_msg_type = '0;
    logic [7:0]  i_frag_index = '0;
    logic [7:0]  i_frag_total = '0;
    logic [7:0]  i_declared_length = '0;
    logic [7:0]  i_actual_length = '0;
    logic [31:0] i_now_time = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_TIMEOUT;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [2:0]  o_slot_used;
    logic [10:0] o_message_bytes;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;

    // running clock in ms for the fragments
    logic [31:0] clock_ms = 32'd100;

    always #1 i_clk = ~i_clk;

    fragment_reassembly_tracker dut (.*);

    fragment_reassembly_tracker_checker checker_i (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // watchdog: any accepted beat or result clears the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // present one fragment and hold start until it is taken
    // start stays high afterwards unless the next beat idles first
    task automatic send_fragment(input logic [7:0] grp, input logic [15:0] src,
                                 input logic [15:0] msg, input logic [7:0] typ,
                                 input logic [7:0] idx, input logic [7:0] tot,
                                 input logic [7:0] dlen, input logic [7:0] alen,
                                 input logic [31:0] now, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_group_id        <= grp;
        i_source_id       <= src;
        i_message_id      <= msg;
        i_msg_type        <= typ;
        i_frag_index      <= idx;
        i_frag_total      <= tot;
        i_declared_length <= dlen;
        i_actual_length   <= alen;
        i_now_time        <= now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // random beat: mostly well formed fragments drawn from a small key pool
    task automatic random_fragment(input bit may_idle);
        logic [7:0]  tot, idx, len;
        logic [15:0] src, msg;
        int pick;
        pick = $urandom_range(0, 19);
        clock_ms = clock_ms + 32'($urandom_range(0, 400));
        if (pick == 0) begin
            // header noise over the full field ranges
            send_fragment(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          $urandom, may_idle);
        end else begin
            tot = (pick < 4) ? 8'd16 : 8'($urandom_range(1, 4));
            idx = 8'($urandom_range(0, tot - 1));
            len = (pick < 4) ? 8'd64 : 8'($urandom_range(0, 64));
            src = (pick == 1) ? 16'($urandom)
                              : (($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0);
            msg = 16'($urandom_range(0, 5));
            if (pick == 2) msg = 16'($urandom);
            send_fragment(($urandom_range(0, 1) != 0) ? 8'hff : 8'h00, src, msg, 8'h5a,
                          idx, tot, len, (pick == 3) ? len + 8'd1 : len,
                          (pick == 4) ? $urandom : clock_ms, may_idle);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: invalid headers of each kind
        send_fragment(8'h00, 16'h0, 16'h0, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 32'd10, 0);
        send_fragment(8'hff, 16'hffff, 16'hffff, 8'hff, 8'd0, 8'd17, 8'd0, 8'd0, 32'd10, 0);
        send_fragment(8'h01, 16'h1, 16'h1, 8'h01, 8'd3, 8'd3, 8'd4, 8'd4, 32'd10, 0);
        send_fragment(8'h01, 16'h1, 16'h1, 8'h01, 8'd0, 8'd3, 8'd65, 8'd65, 32'd10, 0);
        send_fragment(8'h01, 16'h1, 16'h1, 8'h01, 8'd0, 8'd3, 8'd4, 8'd5, 32'd10, 0);
        send_fragment(8'hff, 16'hffff, 16'hffff, 8'hff, 8'd255, 8'd255, 8'd255, 8'd255,
                      32'hffffffff, 0);
        // accepted, duplicate, complete
        send_fragment(8'h01, 16'h1, 16'h1, 8'h01, 8'd0, 8'd2, 8'd64, 8'd64, 32'd20, 0);
        send_fragment(8'h01, 16'h1, 16'h1, 8'h01, 8'd0, 8'd2, 8'd64, 8'd64, 32'd21, 0);
        send_fragment(8'h01, 16'h1, 16'h1, 8'h01, 8'd1, 8'd2, 8'd0, 8'd0, 32'd22, 0);
        // sixteen full fragments, together exactly the byte budget
        for (int k = 0; k < 16; k++)
            send_fragment(8'h02, 16'h2, 16'h2, 8'h02, 8'(k), 8'd16, 8'd64, 8'd64, 32'd30, 0);
        // fill the table beyond its size so the oldest gets evicted
        for (int k = 0; k < 9; k++)
            send_fragment(8'h03, 16'h3, 16'(k), 8'h03, 8'd0, 8'd2, 8'd1, 8'd1, 32'd40, 0);
        // expiry across the signed wrap of the time field
        send_fragment(8'h04, 16'h4, 16'h4, 8'h04, 8'd0, 8'd2, 8'd1, 8'd1, 32'h7fffffff, 0);
        drain();

        // short lifetime and tightest table
        write_reg(CFG_TIMEOUT, 32'd0);
        write_reg(CFG_LIMIT, 32'd0);
        for (int k = 0; k < 60; k++) random_fragment(1);
        drain();
        write_reg(CFG_TIMEOUT, 32'hffffffff);
        write_reg(CFG_LIMIT, 32'd15);
        for (int k = 0; k < 60; k++) random_fragment(1);
        drain();
        write_reg(CFG_TIMEOUT, 32'd700);
        write_reg(CFG_LIMIT, 32'd1);
        for (int k = 0; k < 60; k++) random_fragment(1);
        drain();
        write_reg(CFG_TIMEOUT, 32'd5000);
        write_reg(CFG_LIMIT, 32'd3);
        for (int k = 0; k < 120; k++) random_fragment(1);
        drain();
        write_reg(CFG_TIMEOUT, 32'd2000);
        write_reg(CFG_LIMIT, 32'd8);
        // last stretch with no idling
        for (int k = 0; k < RANDOM_BEATS - 300; k++) random_fragment(0);
        drain();

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
